// File: rtl/core/adpcm_nd_pkg.sv
// Shared types, constants and tables for the ADPCM nibble decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package adpcm_nd_pkg;

  // Field and state widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned PredW    = 12;
  localparam int unsigned StepW    = 11;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 8;
  localparam int unsigned Pcm16W   = 16;
  localparam int unsigned Pcm8W    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Default depth of the nibble queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // Reset and stream-start values
  localparam logic [StepW-1:0] StepInit      = 11'd16;
  localparam logic [IdxW-1:0]  IdxInit       = 6'd1;
  localparam logic [CntW-1:0]  SilenceCntDef = 8'd48;

  // Clamp limits
  localparam logic signed [6:0]  IdxMin  = 7'sd1;
  localparam logic signed [6:0]  IdxMax  = 7'sd49;
  localparam logic signed [13:0] PredMax = 14'sd2047;
  localparam logic signed [13:0] PredMin = -14'sd2048;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgOutput8bit     = 1'b0,
    CfgSilenceResetCnt = 1'b1
  } cfg_reg_e;

  // One nibble on its way from the front to the back
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             start;  // re-initialise state before this nibble
    logic             last;   // low nibble of the byte
  } nibble_item_t;

  // Step index adjustment, indexed by the magnitude bits of the code
  function automatic logic signed [4:0] step_adj(input logic [2:0] mag);
    logic signed [4:0] adj;
    begin
      case (mag)
        3'd4:    adj = 5'sd2;
        3'd5:    adj = 5'sd4;
        3'd6:    adj = 5'sd6;
        3'd7:    adj = 5'sd8;
        default: adj = -5'sd1;
      endcase
      return adj;
    end
  endfunction

  // Step size for a step index; indexes past the table read as zero
  function automatic logic [StepW-1:0] step_lookup(input logic [IdxW-1:0] idx);
    logic [StepW-1:0] s;
    begin
      case (idx)
        6'd0:  s = 11'd0;    6'd1:  s = 11'd16;   6'd2:  s = 11'd17;
        6'd3:  s = 11'd19;   6'd4:  s = 11'd21;   6'd5:  s = 11'd23;
        6'd6:  s = 11'd25;   6'd7:  s = 11'd28;   6'd8:  s = 11'd31;
        6'd9:  s = 11'd34;   6'd10: s = 11'd37;   6'd11: s = 11'd41;
        6'd12: s = 11'd45;   6'd13: s = 11'd50;   6'd14: s = 11'd55;
        6'd15: s = 11'd60;   6'd16: s = 11'd66;   6'd17: s = 11'd73;
        6'd18: s = 11'd80;   6'd19: s = 11'd88;   6'd20: s = 11'd97;
        6'd21: s = 11'd107;  6'd22: s = 11'd118;  6'd23: s = 11'd130;
        6'd24: s = 11'd143;  6'd25: s = 11'd157;  6'd26: s = 11'd173;
        6'd27: s = 11'd190;  6'd28: s = 11'd209;  6'd29: s = 11'd230;
        6'd30: s = 11'd253;  6'd31: s = 11'd279;  6'd32: s = 11'd307;
        6'd33: s = 11'd337;  6'd34: s = 11'd371;  6'd35: s = 11'd408;
        6'd36: s = 11'd449;  6'd37: s = 11'd494;  6'd38: s = 11'd544;
        6'd39: s = 11'd598;  6'd40: s = 11'd658;  6'd41: s = 11'd724;
        6'd42: s = 11'd796;  6'd43: s = 11'd876;  6'd44: s = 11'd963;
        6'd45: s = 11'd1060; 6'd46: s = 11'd1166; 6'd47: s = 11'd1282;
        6'd48: s = 11'd1411; 6'd49: s = 11'd1552;
        default: s = 11'd0;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/adpcm_nibble_decoder.sv
// 4-bit OKI/Dialogic ADPCM decoder, top level.
// Channels: input (in_valid_i/in_ready_o) carries one byte plus a start flag;
// output (out_valid_o/out_ready_i) carries one sample per transaction, two per
// byte, high nibble first, last_o marking the low-nibble sample.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0: output_8bit, 1: silence_reset_count); write only while idle.
// Path: a taken byte passes the byte register, the nibble queue and the
// output register; the low-nibble sample follows the high-nibble one.
// Throughput: one sample per cycle while out_ready_i stays high; the front end
// takes the next byte in the cycle the low nibble of the last one leaves, and the
// back end updates the predictor and step state once per nibble.
// A nibble queue (QueueDepth entries) between front and back lets the front
// keep taking bytes while the output stalls; when out_ready_i stays low the
// output register, queue and byte register fill and in_ready_o drops.
// Reset: predictor 0, step 16, step index 1, silence counter 0,
// output_8bit 0, silence_reset_count 48; pipeline empty.
// Depends on adpcm_nd_pkg, adpcm_nd_front, adpcm_nd_queue, adpcm_nd_back.
`default_nettype none

module adpcm_nibble_decoder #(
  parameter int unsigned QueueDepth = adpcm_nd_pkg::QueueDepthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [adpcm_nd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [adpcm_nd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [adpcm_nd_pkg::ByteW-1:0]      adpcm_byte_i,
  input  wire logic                                start_of_stream_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [adpcm_nd_pkg::Pcm16W-1:0] pcm16_o,
  output      logic [adpcm_nd_pkg::Pcm8W-1:0]      pcm8_o,
  output      logic                                last_o
);
  import adpcm_nd_pkg::*;

  logic            out8_q, out8_d;
  logic [CntW-1:0] silence_cnt_q, silence_cnt_d;

  logic         push_valid, push_ready;
  nibble_item_t push_item;
  logic         pop_valid, pop_ready;
  nibble_item_t pop_item;
  logic [$clog2(QueueDepth+1)-1:0] q_level;

  // Configuration registers
  always_comb begin
    out8_d        = out8_q;
    silence_cnt_d = silence_cnt_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgOutput8bit:      out8_d        = cfg_data_i[0];
        CfgSilenceResetCnt: silence_cnt_d = cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out8_q        <= 1'b0;
      silence_cnt_q <= SilenceCntDef;
    end else begin
      out8_q        <= out8_d;
      silence_cnt_q <= silence_cnt_d;
    end
  end

  // Front end: byte to nibbles
  adpcm_nd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .adpcm_byte_i      (adpcm_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_item_o       (push_item)
  );

  // Nibble queue
  adpcm_nd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item),
    .level_o      (q_level)
  );

  // Back end: decode and output
  adpcm_nd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_output_8bit_i (out8_q),
    .cfg_silence_cnt_i (silence_cnt_q),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_item_i        (pop_item),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pcm16_o           (pcm16_o),
    .pcm8_o            (pcm8_o),
    .last_o            (last_o)
  );

  // A freshly taken byte keeps the input blocked while its high nibble is held
  a_byte_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while the high nibble is still held");

  // Queue never overfills
  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("nibble queue level above depth");

  // In 8-bit mode the 16-bit field reads zero
  a_pcm16_zero_in_8bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out8_q |-> pcm16_o == '0)
    else $error("pcm16 not zero in 8-bit mode");

endmodule

`default_nettype wire

// File: rtl/core/adpcm_nd_front.sv
// Front end: accepts ADPCM bytes and splits each into two nibble transactions.
// Depends on adpcm_nd_pkg.
`default_nettype none

module adpcm_nd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [adpcm_nd_pkg::ByteW-1:0] adpcm_byte_i,
  input  wire logic                          start_of_stream_i,
  output      logic                          push_valid_o,
  input  wire logic                          push_ready_i,
  output      adpcm_nd_pkg::nibble_item_t    push_item_o
);
  import adpcm_nd_pkg::*;

  logic             hold_q, hold_d;
  logic             phase_q, phase_d;   // 0: high nibble next, 1: low nibble next
  logic [ByteW-1:0] byte_q, byte_d;
  logic             start_q, start_d;
  logic             in_fire, push_fire;

  // Ready when empty, or when the low nibble leaves this cycle
  assign in_ready_o = !hold_q || (phase_q && push_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_fire  = push_valid_o && push_ready_i;

  // Nibble presented to the queue
  assign push_valid_o      = hold_q;
  assign push_item_o.code  = phase_q ? byte_q[CodeW-1:0] : byte_q[ByteW-1:CodeW];
  assign push_item_o.start = start_q && !phase_q;
  assign push_item_o.last  = phase_q;

  // Byte holding register and nibble phase
  always_comb begin
    hold_d  = hold_q;
    phase_d = phase_q;
    byte_d  = byte_q;
    start_d = start_q;
    if (in_fire) begin
      hold_d  = 1'b1;
      phase_d = 1'b0;
      byte_d  = adpcm_byte_i;
      start_d = start_of_stream_i;
    end else if (push_fire && phase_q) begin
      hold_d  = 1'b0;
      phase_d = 1'b0;
    end else if (push_fire) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/adpcm_nd_queue.sv
// Short FIFO of nibble transactions between the front and the back end.
// Depends on adpcm_nd_pkg.
`default_nettype none

module adpcm_nd_queue #(
  parameter int unsigned Depth = adpcm_nd_pkg::QueueDepthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_valid_i,
  output      logic                       push_ready_o,
  input  wire adpcm_nd_pkg::nibble_item_t push_item_i,
  output      logic                       pop_valid_o,
  input  wire logic                       pop_ready_i,
  output      adpcm_nd_pkg::nibble_item_t pop_item_o,
  output      logic [$clog2(Depth+1)-1:0] level_o
);
  import adpcm_nd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW_ = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(Depth - 1);
  localparam logic [CntW_-1:0] CntFull  = CntW_'(Depth);

  nibble_item_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW_-1:0] cnt_q, cnt_d;
  logic            push_fire, pop_fire;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign level_o      = cnt_q;
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_fire && !push_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/adpcm_nd_back.sv
// Back end: decodes one nibble per cycle while the output is not stalled, holds the
// decoder state and the output register. Depends on adpcm_nd_pkg.
`default_nettype none

module adpcm_nd_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_output_8bit_i,
  input  wire logic [adpcm_nd_pkg::CntW-1:0]   cfg_silence_cnt_i,
  input  wire logic                            pop_valid_i,
  output      logic                            pop_ready_o,
  input  wire adpcm_nd_pkg::nibble_item_t      pop_item_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic signed [adpcm_nd_pkg::Pcm16W-1:0] pcm16_o,
  output      logic [adpcm_nd_pkg::Pcm8W-1:0]  pcm8_o,
  output      logic                            last_o
);
  import adpcm_nd_pkg::*;

  // Decoder state
  logic signed [PredW-1:0] pred_q, pred_d;
  logic [StepW-1:0]        step_q, step_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic signed [Pcm16W-1:0] pcm16_q, pcm16_d;
  logic [Pcm8W-1:0]         pcm8_q, pcm8_d;
  logic                     last_q, last_d;

  // Working values
  logic signed [PredW-1:0] pred0;
  logic [StepW-1:0]        step0;
  logic [IdxW-1:0]         idx0;
  logic [CntW-1:0]         cnt0, cnt1;
  logic [12:0]             delta;
  logic signed [13:0]      pred_sum;
  logic signed [PredW-1:0] pred_new;
  logic signed [6:0]       idx_sum;
  logic [IdxW-1:0]         idx_new;
  logic [CodeW-1:0]        code;
  logic                    fire;
  logic                    silence_hit;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;
  assign code        = pop_item_i.code;

  // Nibble decode
  always_comb begin
    // stream start re-initialises before the nibble
    if (pop_item_i.start) begin
      pred0 = '0;
      step0 = StepInit;
      idx0  = IdxInit;
      cnt0  = '0;
    end else begin
      pred0 = pred_q;
      step0 = step_q;
      idx0  = idx_q;
      cnt0  = cnt_q;
    end

    cnt1 = (code[2:0] == 3'd0) ? cnt0 + 1'b1 : cnt0;

    delta = 13'(step0 >> 3);
    if (code[2]) delta = delta + 13'(step0);
    if (code[1]) delta = delta + 13'(step0 >> 1);
    if (code[0]) delta = delta + 13'(step0 >> 2);

    if (code[3]) pred_sum = 14'(pred0) - $signed({1'b0, delta});
    else         pred_sum = 14'(pred0) + $signed({1'b0, delta});

    if (pred_sum > PredMax)      pred_new = PredW'(PredMax);
    else if (pred_sum < PredMin) pred_new = PredW'(PredMin);
    else                         pred_new = pred_sum[PredW-1:0];

    idx_sum = $signed({1'b0, idx0}) + 7'(step_adj(code[2:0]));
    if (idx_sum < IdxMin)      idx_new = IdxW'(IdxMin);
    else if (idx_sum > IdxMax) idx_new = IdxW'(IdxMax);
    else                       idx_new = idx_sum[IdxW-1:0];

    silence_hit = (cnt1 == cfg_silence_cnt_i);
  end

  // State update
  always_comb begin
    pred_d = pred_q;
    step_d = step_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    if (fire) begin
      idx_d = idx_new;
      if (silence_hit) begin
        pred_d = '0;
        step_d = StepInit;
        cnt_d  = '0;
      end else begin
        pred_d = pred_new;
        step_d = step_lookup(idx_new);
        cnt_d  = cnt1;
      end
    end
  end

  // Output formatting and register
  always_comb begin
    out_valid_d = out_valid_q;
    pcm16_d     = pcm16_q;
    pcm8_d      = pcm8_q;
    last_d      = last_q;
    if (fire) begin
      out_valid_d = 1'b1;
      last_d      = pop_item_i.last;
      if (cfg_output_8bit_i) begin
        pcm16_d = '0;
        // predictor >> 4 already fits -128..127; offset by flipping the sign bit
        pcm8_d  = {~pred_new[PredW-1], pred_new[PredW-2:4]};
      end else begin
        pcm16_d = {pred_new, 4'b0000};
        pcm8_d  = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q      <= '0;
      step_q      <= StepInit;
      idx_q       <= IdxInit;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pred_q      <= pred_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pcm16_q <= pcm16_d;
    pcm8_q  <= pcm8_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign pcm16_o     = pcm16_q;
  assign pcm8_o      = pcm8_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
